@@ hw/rtl/gbpf_pkg.sv @@
// Package for the grid path finder: sizes, codes, state enum and small helpers.
// Used by grid_bfs_path_finder_core; depends on nothing.
package gbpf_pkg;
	localparam int MAX_COLS   = 64;
	localparam int MAX_ROWS   = 64;
	localparam int RING_LIMIT = 12;
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CELLS  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int CNT_W  = ADDR_W + 1;
	localparam int RING_W = $clog2(RING_LIMIT + 1) + 1;
	// Signed coordinate width, wide enough for a ring offset past either edge.
	localparam int SC_W   = COL_W + RING_W + 2;
	localparam logic signed [SC_W-1:0] SC_ONE = SC_W'(1);

	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_CELL = 2'd1;
	localparam logic [1:0] ST_NO_PATH = 2'd2;
	localparam logic [1:0] ST_BEYOND  = 2'd3;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_RD_WAIT, S_OUT,
		S_SNAP_CHK, S_SNAP_WAIT, S_SNAP_EVAL,
		S_CLR, S_SEED,
		S_POP, S_POP_WAIT, S_POP_EVAL,
		S_NB, S_NB_WAIT, S_NB_EVAL,
		S_CNT, S_CNT_WAIT,
		S_WR, S_WR_WAIT
	} state_t;
endpackage

@@ hw/rtl/gbpf_ram.sv @@
// Generic single-port-write, single-read synchronous RAM with registered read.
// Standalone; no package needed.
module gbpf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hw/rtl/grid_bfs_path_finder_core.sv @@
// Grid path finder top level: sequencer around the walk, seen, parent, queue and path memories.
// Depends on gbpf_pkg and gbpf_ram.
//
// Usage. Items arrive on the in channel (valid/ready) and each gives exactly
// one result transaction on the out channel. A load writes one cell of the
// walkable map; a find snaps start and goal to the nearest walkable cell,
// runs a breadth-first search and stores the path; a read returns a waypoint.
// The user must write grid size on the cfg channel only while the block is idle;
// the block itself does not enforce it. A find scans up to 12 rings around each
// endpoint, reading perimeter cells and skipping interior ones, clears the seen
// map in a pass over all 4096 cells, pops cells and checks their in-grid
// neighbours, and walks the parent chain twice, once to count the waypoints
// and once to store them. When both endpoints snap to one cell, the search
// is skipped. Each memory has a single read port, so its reads run one at a
// time.
// The block takes one item at a time. The result sits in an output register
// until taken, so a stalled receiver simply holds the block in its output
// state. Reset clears control state, and the walkable map is cleared to all
// blocked by a sweep over all 4096 cells after reset, during which no item
// is accepted.
module grid_bfs_path_finder_core
	import gbpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [11:0] load_index,
	input  logic        walkable_bit,
	input  logic [5:0]  start_col,
	input  logic [5:0]  start_row,
	input  logic [5:0]  goal_col,
	input  logic [5:0]  goal_row,
	input  logic [11:0] waypoint_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [12:0] path_length,
	output logic [5:0]  waypoint_col,
	output logic [5:0]  waypoint_row
);
	// Configuration registers, raw as written.
	logic [6:0] gw_q, gh_q;
	logic [COL_W:0] effw, effh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'd64;
			gh_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WIDTH) gw_q <= cfg_data;
			else gh_q <= cfg_data;
		end
	end
	assign cfg_ready = 1'b1;

	always_comb begin
		effw = (gw_q == 7'd0) ? (COL_W+1)'(1) :
			(gw_q > 7'(MAX_COLS)) ? (COL_W+1)'(MAX_COLS) : (COL_W+1)'(gw_q);
		effh = (gh_q == 7'd0) ? (ROW_W+1)'(1) :
			(gh_q > 7'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(gh_q);
	end

	// Memory ports.
	logic walk_we, walk_wd, walk_rd;
	addr_t walk_wa, walk_ra;
	logic seen_we, seen_wd, seen_rd;
	addr_t seen_wa, seen_ra;
	logic par_we;
	addr_t par_wa, par_wd, par_ra, par_rd;
	logic q_we;
	addr_t q_wa, q_wd, q_ra, q_rd;
	logic p_we;
	addr_t p_wa, p_wd, p_ra, p_rd;

	gbpf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_walk (.clk, .we(walk_we), .waddr(walk_wa),
		.wdata(walk_wd), .raddr(walk_ra), .rdata(walk_rd));
	gbpf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_seen (.clk, .we(seen_we), .waddr(seen_wa),
		.wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd));
	gbpf_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_par (.clk, .we(par_we), .waddr(par_wa),
		.wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
	gbpf_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_queue (.clk, .we(q_we), .waddr(q_wa),
		.wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
	gbpf_ram #(.WIDTH(ADDR_W), .DEPTH(CELLS)) u_path (.clk, .we(p_we), .waddr(p_wa),
		.wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

	// Control registers.
	state_t state_q, state_d;
	logic init_q;                 // walk map clearing sweep after reset
	addr_t sweep_q;
	logic [11:0] idx_q;
	logic [1:0] status_q;
	logic [CNT_W-1:0] pcount_q;
	logic [5:0] wcol_q, wrow_q;
	logic end_q;                  // 0 start, 1 goal being snapped
	logic [COL_W-1:0] cc_q;       // clamped centre
	logic [ROW_W-1:0] cr_q;
	logic [COL_W-1:0] gc_q;       // clamped goal, held until the goal is snapped
	logic [ROW_W-1:0] gr_q;
	logic [RING_W-1:0] ring_q;
	logic signed [SC_W-1:0] dx_q, dy_q;
	addr_t s_q, g_q, cur_q, at_q;
	logic [1:0] nb_q;
	logic [CNT_W-1:0] head_q, tail_q, len_q, k_q;
	logic cand_ok_q;              // candidate cell lies inside the grid
	addr_t cand_q;

	logic [COL_W-1:0] ccl, gcl;
	logic [ROW_W-1:0] rcl, grl;
	logic signed [SC_W-1:0] tc, tr, nc, nr;
	logic t_in, n_in, on_perim;

	// Clamp of the incoming endpoints.
	always_comb begin
		ccl = ({1'b0, start_col} >= 7'(effw)) ? COL_W'(effw - 1'b1) : COL_W'(start_col);
		rcl = ({1'b0, start_row} >= 7'(effh)) ? ROW_W'(effh - 1'b1) : ROW_W'(start_row);
		gcl = ({1'b0, goal_col} >= 7'(effw)) ? COL_W'(effw - 1'b1) : COL_W'(goal_col);
		grl = ({1'b0, goal_row} >= 7'(effh)) ? ROW_W'(effh - 1'b1) : ROW_W'(goal_row);
	end

	// Ring candidate and BFS neighbour coordinates.
	always_comb begin
		tc = $signed({{(SC_W-COL_W){1'b0}}, cc_q}) + dx_q;
		tr = $signed({{(SC_W-ROW_W){1'b0}}, cr_q}) + dy_q;
		t_in = (tc >= 0) && (tr >= 0) && (tc < $signed(SC_W'(effw)))
			&& (tr < $signed(SC_W'(effh)));
		on_perim = (dx_q == $signed(SC_W'(ring_q))) || (dx_q == -$signed(SC_W'(ring_q)))
			|| (dy_q == $signed(SC_W'(ring_q))) || (dy_q == -$signed(SC_W'(ring_q)));
		nc = $signed({{(SC_W-COL_W){1'b0}}, cur_q[COL_W-1:0]});
		nr = $signed({{(SC_W-ROW_W){1'b0}}, cur_q[ADDR_W-1:COL_W]});
		case (nb_q)
			2'd0: nc = nc + SC_ONE;
			2'd1: nc = nc - SC_ONE;
			2'd2: nr = nr + SC_ONE;
			default: nr = nr - SC_ONE;
		endcase
		n_in = (nc >= 0) && (nr >= 0) && (nc < $signed(SC_W'(effw)))
			&& (nr < $signed(SC_W'(effh)));
	end

	addr_t t_addr, n_addr;
	assign t_addr = {tr[ROW_W-1:0], tc[COL_W-1:0]};
	assign n_addr = {nr[ROW_W-1:0], nc[COL_W-1:0]};

	assign in_ready  = (state_q == S_IDLE) && !init_q;
	assign out_valid = (state_q == S_OUT);
	assign status       = status_q;
	assign path_length  = 13'(pcount_q);
	assign waypoint_col = wcol_q;
	assign waypoint_row = wrow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q  <= 1'b1;
			sweep_q <= '0;
			pcount_q <= '0;
		end else begin
			state_q <= state_d;
			if (init_q) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_q == addr_t'(CELLS - 1)) init_q <= 1'b0;
			end else if (state_q == S_CLR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (state_q == S_IDLE && in_valid && in_ready && operation == OP_FIND)
				pcount_q <= '0;
			else if (state_q == S_SNAP_EVAL && end_q && walk_rd && cand_ok_q
				&& s_q == cand_q)
				pcount_q <= CNT_W'(1);
			else if (state_q == S_WR && k_q == CNT_W'(1))
				pcount_q <= len_q;
		end
	end

	// Next state, memory controls.
	always_comb begin
		state_d = state_q;
		walk_we = init_q; walk_wa = sweep_q; walk_wd = 1'b0; walk_ra = t_addr;
		seen_we = 1'b0; seen_wa = sweep_q; seen_wd = 1'b0; seen_ra = n_addr;
		par_we = 1'b0; par_wa = n_addr; par_wd = cur_q; par_ra = at_q;
		q_we = 1'b0; q_wa = tail_q[ADDR_W-1:0]; q_wd = n_addr; q_ra = head_q[ADDR_W-1:0];
		p_we = 1'b0; p_wa = k_q[ADDR_W-1:0] - 1'b1; p_wd = at_q; p_ra = idx_q;
		case (state_q)
			S_IDLE: begin
				// The waypoint is looked up at the accepting edge.
				p_ra = waypoint_index;
				if (in_valid && in_ready) begin
					case (operation)
						OP_LOAD: begin
							walk_we = 1'b1; walk_wa = load_index; walk_wd = walkable_bit;
							state_d = S_OUT;
						end
						OP_FIND: state_d = S_SNAP_CHK;
						OP_READ: state_d = S_RD_WAIT;
						default: state_d = S_OUT;
					endcase
				end
			end
			S_RD_WAIT: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = S_IDLE;
			S_SNAP_CHK: begin
				if (ring_q == '0 || on_perim) begin
					state_d = S_SNAP_WAIT;
				end else begin
					state_d = S_SNAP_CHK; // skip interior cell
				end
				if (ring_q == RING_W'(RING_LIMIT + 1)) state_d = S_OUT;
			end
			S_SNAP_WAIT: state_d = S_SNAP_EVAL;
			S_SNAP_EVAL: begin
				if (walk_rd && cand_ok_q) begin
					if (!end_q) begin
						state_d = S_SNAP_CHK;
					end else if (s_q == cand_q) begin
						// Start and goal coincide: the path is that one cell.
						p_we = 1'b1; p_wa = '0; p_wd = cand_q;
						state_d = S_OUT;
					end else begin
						state_d = S_CLR;
					end
				end else begin
					state_d = S_SNAP_CHK;
				end
			end
			S_CLR: begin
				seen_we = 1'b1;
				if (sweep_q == addr_t'(CELLS - 1)) state_d = S_SEED;
			end
			S_SEED: begin
				seen_we = 1'b1; seen_wa = s_q; seen_wd = 1'b1;
				q_we = 1'b1; q_wa = '0; q_wd = s_q;
				state_d = S_POP;
			end
			S_POP: state_d = (head_q < tail_q) ? S_POP_WAIT : S_OUT;
			S_POP_WAIT: state_d = S_POP_EVAL;
			S_POP_EVAL: state_d = (q_rd == g_q) ? S_CNT : S_NB;
			S_NB: begin
				walk_ra = n_addr;
				state_d = n_in ? S_NB_WAIT : ((nb_q == 2'd3) ? S_POP : S_NB);
			end
			S_NB_WAIT: begin
				walk_ra = n_addr;
				state_d = S_NB_EVAL;
			end
			S_NB_EVAL: begin
				if (walk_rd && !seen_rd) begin
					seen_we = 1'b1; seen_wa = n_addr; seen_wd = 1'b1;
					par_we = 1'b1;
					q_we = (tail_q < CNT_W'(CELLS));
				end
				state_d = (nb_q == 2'd3) ? S_POP : S_NB;
			end
			S_CNT: state_d = (at_q == s_q) ? S_WR : S_CNT_WAIT;
			S_CNT_WAIT: state_d = S_CNT;
			S_WR: begin
				p_we = 1'b1;
				state_d = (k_q == CNT_W'(1)) ? S_OUT : S_WR_WAIT;
			end
			S_WR_WAIT: state_d = S_WR;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q <= waypoint_index;
				status_q <= ST_OK; wcol_q <= '0; wrow_q <= '0;
				end_q <= 1'b0; ring_q <= '0; dx_q <= '0; dy_q <= '0;
				cc_q <= ccl; cr_q <= rcl; gc_q <= gcl; gr_q <= grl;
				head_q <= '0; tail_q <= CNT_W'(1);
			end
			S_RD_WAIT: begin
				if ({1'b0, idx_q} < pcount_q) begin
					wcol_q <= 6'(p_rd[COL_W-1:0]); wrow_q <= 6'(p_rd[ADDR_W-1:COL_W]);
				end else begin
					status_q <= ST_BEYOND;
				end
			end
			S_SNAP_CHK: begin
				cand_ok_q <= t_in; cand_q <= t_addr;
				if (ring_q == RING_W'(RING_LIMIT + 1)) status_q <= ST_NO_CELL;
				if (ring_q != '0 && !on_perim) begin
					// step to the next cell of the ring scan
					if (dx_q == $signed(SC_W'(ring_q))) begin
						dx_q <= -$signed(SC_W'(ring_q)); dy_q <= dy_q + SC_ONE;
					end else begin
						dx_q <= dx_q + SC_ONE;
					end
				end
			end
			S_SNAP_EVAL: begin
				if (walk_rd && cand_ok_q) begin
					if (!end_q) s_q <= cand_q;
					end_q <= 1'b1; ring_q <= '0; dx_q <= '0; dy_q <= '0;
					cc_q <= gc_q; cr_q <= gr_q;
					if (end_q) begin
						g_q <= cand_q; at_q <= cand_q; len_q <= CNT_W'(1);
					end
				end else if (ring_q == '0 ||
					(dx_q == $signed(SC_W'(ring_q)) && dy_q == $signed(SC_W'(ring_q)))) begin
					ring_q <= ring_q + 1'b1;
					dx_q <= -$signed(SC_W'(ring_q + 1'b1));
					dy_q <= -$signed(SC_W'(ring_q + 1'b1));
				end else if (dx_q == $signed(SC_W'(ring_q))) begin
					dx_q <= -$signed(SC_W'(ring_q)); dy_q <= dy_q + SC_ONE;
				end else begin
					dx_q <= dx_q + SC_ONE;
				end
			end
			S_POP: if (!(head_q < tail_q)) status_q <= ST_NO_PATH;
			S_POP_EVAL: begin
				cur_q <= q_rd; head_q <= head_q + 1'b1; nb_q <= 2'd0;
			end
			S_NB: if (!n_in) nb_q <= nb_q + 1'b1;
			S_NB_EVAL: begin
				if (walk_rd && !seen_rd && tail_q < CNT_W'(CELLS)) tail_q <= tail_q + 1'b1;
				nb_q <= nb_q + 1'b1;
			end
			S_CNT: begin
				if (at_q == s_q) begin
					at_q <= g_q; k_q <= len_q;
				end
			end
			S_CNT_WAIT: begin
				at_q <= par_rd; len_q <= len_q + 1'b1;
			end
			S_WR: k_q <= k_q - 1'b1;
			S_WR_WAIT: at_q <= par_rd;
			default: ;
		endcase
	end

	// A result is only offered while the block is out of reset sweep.
	a_no_out_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !out_valid) else $error("result during clearing sweep");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CNT_W'(CELLS)) else $error("queue overrun");
endmodule
